/* rtl/sha224_pkg.sv */
// Shared types, constants and helpers for the SHA-224 hash engine.
// No dependencies; every other file imports this package.
package sha224_pkg;

    localparam int WordW = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Control bundle from the sequencer to the datapath
    typedef struct packed {
        logic       init_hash;
        logic       load_work;
        logic       shift_word;
        logic       round_en;
        logic       add_en;
        logic [5:0] round_idx;
        logic [2:0] out_idx;
    } ctrl_t;

    localparam logic [2:0] LastIdx = 3'd6;
    localparam logic [5:0] LastRound = 6'd63;
    localparam logic [3:0] LastWord = 4'd15;

    localparam logic [WordW-1:0] INIT_HASH [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam logic [WordW-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Rotate right by a constant amount
    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

/* rtl/sha224_if.sv */
// Handshake channel interfaces for the SHA-224 hash engine.
// Depends on sha224_pkg for the word width.
interface sha224_msg_if
    import sha224_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [WordW-1:0] message_word;
    logic             message_start;
    logic             message_end;

    modport source (output valid, message_word, message_start, message_end, input ready);
    modport sink   (input valid, message_word, message_start, message_end, output ready);
endinterface

interface sha224_dig_if
    import sha224_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [WordW-1:0] digest_word;
    logic [2:0]       digest_index;
    logic             digest_last;

    modport source (output valid, digest_word, digest_index, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

/* rtl/sha224_ctrl.sv */
// Sequencer: word counting, round counting and digest readout.
// Depends on sha224_pkg.
module sha224_ctrl
    import sha224_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  msg_valid,
    input  logic  msg_start,
    input  logic  msg_end,
    output logic  msg_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output ctrl_t ctrl
);

    state_t     state_reg, state_next;
    logic [3:0] word_reg, word_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       end_reg, end_next;
    logic       accept;
    logic       block_done;
    logic       out_take;

    assign accept     = msg_valid && msg_ready;
    assign block_done = !msg_start && (word_reg == LastWord);
    assign out_take   = out_valid && out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && block_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LastRound)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = end_reg ? ST_OUT : ST_LOAD;
            end
            ST_OUT:
            begin
                if (out_take && idx_reg == LastIdx)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        msg_ready      = (state_reg == ST_LOAD);
        out_valid      = (state_reg == ST_OUT);
        ctrl.init_hash  = accept && msg_start;
        ctrl.load_work  = accept && block_done;
        ctrl.shift_word = accept;
        ctrl.round_en   = (state_reg == ST_ROUND);
        ctrl.add_en     = (state_reg == ST_ADD);
        ctrl.round_idx  = round_reg;
        ctrl.out_idx    = idx_reg;
    end

    // Counters
    always_comb
    begin
        word_next  = word_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        if (accept)
        begin
            // start restarts the block; this word becomes word 0
            word_next = msg_start ? 4'd1 : word_reg + 4'd1;
            if (block_done)
            begin
                end_next = msg_end;
            end
        end
        if (state_reg == ST_ROUND)
        begin
            round_next = round_reg + 6'd1;
        end
        if (out_take)
        begin
            idx_next = (idx_reg == LastIdx) ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            word_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
        end
    end

endmodule

/* rtl/sha224_sched.sv */
// Message schedule: sixteen-word shift window and the schedule expansion.
// Depends on sha224_pkg.
module sha224_sched
    import sha224_pkg::*;
(
    input  logic             clk,
    input  ctrl_t            ctrl,
    input  logic [WordW-1:0] word,
    output logic [WordW-1:0] wt
);

    // Entry 0 is the oldest word, entry 15 the newest
    logic [WordW-1:0] win_reg [16];
    logic [WordW-1:0] s0;
    logic [WordW-1:0] s1;
    logic [WordW-1:0] expand;
    logic             early;

    assign early = (ctrl.round_idx[5:4] == 2'b00);

    // Schedule expansion from the window taps
    always_comb
    begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        expand = s1 + win_reg[9] + s0 + win_reg[0];
        wt = early ? win_reg[0] : expand;
    end

    // Shift in message words, then rotate (first 16 rounds) or expand
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_word || ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= ctrl.shift_word ? word : wt;
        end
    end

endmodule

/* rtl/sha224_round.sv */
// Compression datapath: hash state, working variables and one shared round unit.
// Depends on sha224_pkg.
module sha224_round
    import sha224_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  logic [WordW-1:0] wt,
    output logic [WordW-1:0] digest_word
);

    logic [WordW-1:0] hash_reg [8];
    logic [WordW-1:0] work_reg [8];
    logic [WordW-1:0] big0, big1, ch, maj, t1, t2;

    // One SHA-256 round on the working variables
    always_comb
    begin
        big1 = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
        ch   = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1   = work_reg[7] + big1 + ch + ROUND_K[ctrl.round_idx] + wt;
        big0 = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
        maj  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
             ^ (work_reg[1] & work_reg[2]);
        t2   = big0 + maj;
    end

    assign digest_word = hash_reg[ctrl.out_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
                work_reg[i] <= '0;
            end
        end
        else
        begin
            // Hash state: reload on start, accumulate after the rounds
            if (ctrl.init_hash)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= INIT_HASH[i];
                end
            end
            else if (ctrl.add_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end

            // Working variables
            if (ctrl.load_work)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    work_reg[i] <= hash_reg[i];
                end
            end
            else if (ctrl.round_en)
            begin
                work_reg[7] <= work_reg[6];
                work_reg[6] <= work_reg[5];
                work_reg[5] <= work_reg[4];
                work_reg[4] <= work_reg[3] + t1;
                work_reg[3] <= work_reg[2];
                work_reg[2] <= work_reg[1];
                work_reg[1] <= work_reg[0];
                work_reg[0] <= t1 + t2;
            end
        end
    end

endmodule

/* rtl/sha224_hash_engine.sv */
// SHA-224 hash engine top level: sequencer, message schedule and round unit.
// Sequence: the sixteenth word of a block is followed by the 64 rounds and the
// accumulate step; on the final block the seven digest items follow, one per cycle
// while dig.ready is high. Throughput per 16-word block is set by the single round
// unit running one round per cycle; input is not taken during rounds or digest readout.
// Reset: asynchronous, active low; loads the SHA-224 initial hash, clears all counters.
module sha224_hash_engine
    import sha224_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha224_msg_if.sink   msg,
    sha224_dig_if.source dig
);

    ctrl_t            ctrl;
    logic [WordW-1:0] wt;
    logic [WordW-1:0] digest_word;

    sha224_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_start (msg.message_start),
        .msg_end   (msg.message_end),
        .msg_ready (msg.ready),
        .out_valid (dig.valid),
        .out_ready (dig.ready),
        .ctrl      (ctrl)
    );

    sha224_sched u_sched (
        .clk  (clk),
        .ctrl (ctrl),
        .word (msg.message_word),
        .wt   (wt)
    );

    sha224_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .wt          (wt),
        .digest_word (digest_word)
    );

    // Digest item fields
    assign dig.digest_word  = digest_word;
    assign dig.digest_index = ctrl.out_idx;
    assign dig.digest_last  = (ctrl.out_idx == LastIdx);

endmodule

/* bench/tb_sha224_hash_engine.sv */
// Self-checking bench for sha224_hash_engine: padded message words in, digest items out.
// Depends on sha224_pkg and the channel interfaces in sha224_if; keeps its own SHA-224
// model, constants included, so a wrong table in the block does not hide itself.
module tb_sha224_hash_engine;
    import sha224_pkg::*;

    localparam int TotalWords = 230;
    localparam int CycleLimit = 200000;
    localparam int TailCycles = 200;

    localparam logic [0:7][31:0] Sha224Iv = {
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam logic [0:63][31:0] RoundConst = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic        start_flag;
        logic        end_flag;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] dword;
        logic [2:0]  pos;
        logic        last;
    } digest_item_t;

    // Receiver behaviour: always open, coin toss, or mostly stalled
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_THROTTLED
    } rx_mode_t;

    logic clk;
    logic rst_n;

    sha224_msg_if msg_ch ();
    sha224_dig_if dig_ch ();

    sha224_hash_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .dig   (dig_ch)
    );

    msg_item_t    words_pending [$];
    digest_item_t digest_due [$];

    // Model state: running hash, current block, word position within it
    logic [31:0] hash_state [8];
    logic [31:0] block_buf [16];
    logic [3:0]  word_pos;

    int words_taken;
    int blocks_hashed;
    int digest_items_seen;
    int error_count;
    int cycle_count;

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // 64 rounds over block_buf, then fold into the running hash
    function automatic void hash_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, ch, mj, t1, t2;
        for (int t = 0; t < 16; t++)
            sched[t] = block_buf[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
        end
        for (int j = 0; j < 8; j++)
            v[j] = hash_state[j];
        for (int t = 0; t < 64; t++)
        begin
            s1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + RoundConst[t] + sched[t];
            s0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_state[j] = hash_state[j] + v[j];
    endfunction

    // One accepted message word: reload, store, and on a full final block queue the digest
    function automatic void absorb_word(input logic [31:0] word, input logic start_flag,
                                        input logic end_flag);
        if (start_flag)
        begin
            for (int j = 0; j < 8; j++)
                hash_state[j] = Sha224Iv[j];
            word_pos = '0;
        end
        block_buf[word_pos] = word;
        if (word_pos == LastWord)
        begin
            hash_block();
            blocks_hashed++;
            if (end_flag)
                for (int k = 0; k < 7; k++)
                    digest_due.push_back('{dword: hash_state[k], pos: 3'(k), last: (k == 6)});
        end
        word_pos = word_pos + 4'd1;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_word(input logic [31:0] word, input logic start_flag,
                                       input logic end_flag);
        words_pending.push_back('{word: word, start_flag: start_flag, end_flag: end_flag});
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t timeout after %0d cycles, %0d digest items outstanding",
                     $time, cycle_count, digest_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        msg_item_t next_item;
        if (!rst_n)
        begin
            msg_ch.valid         <= 1'b0;
            msg_ch.message_word  <= '0;
            msg_ch.message_start <= 1'b0;
            msg_ch.message_end   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                absorb_word(msg_ch.message_word, msg_ch.message_start, msg_ch.message_end);
                words_taken++;
            end
            if (!msg_ch.valid || msg_ch.ready)
            begin
                if (gap_left != 0 || words_pending.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    msg_ch.valid <= 1'b0;
                end
                else
                begin
                    next_item = words_pending.pop_front();
                    msg_ch.valid         <= 1'b1;
                    msg_ch.message_word  <= next_item.word;
                    msg_ch.message_start <= next_item.start_flag;
                    msg_ch.message_end   <= next_item.end_flag;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: ready pattern switches between the three modes at random
    rx_mode_t rx_mode;
    int       rx_mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_ch.ready <= 1'b0;
            rx_mode      = RX_OPEN;
            rx_mode_left = 0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(4, 40);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   dig_ch.ready <= 1'b1;
                RX_RANDOM: dig_ch.ready <= 1'($urandom_range(0, 1));
                default:   dig_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Digest checker
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            digest_items_seen++;
            if (digest_due.size() == 0)
            begin
                $display("%0t unexpected digest item: expected none, got word %h pos %0d last %b",
                         $time, dig_ch.digest_word, dig_ch.digest_index, dig_ch.digest_last);
                error_count++;
            end
            else
            begin
                want = digest_due.pop_front();
                if (dig_ch.digest_word !== want.dword)
                begin
                    $display("%0t digest_word mismatch: expected %h, got %h",
                             $time, want.dword, dig_ch.digest_word);
                    error_count++;
                end
                if (dig_ch.digest_index !== want.pos)
                begin
                    $display("%0t digest_index mismatch: expected %0d, got %0d",
                             $time, want.pos, dig_ch.digest_index);
                    error_count++;
                end
                if (dig_ch.digest_last !== want.last)
                begin
                    $display("%0t digest_last mismatch: expected %b, got %b",
                             $time, want.last, dig_ch.digest_last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int n_blocks;
        int n_noise;

        rst_n                = 1'b0;
        msg_ch.valid         = 1'b0;
        msg_ch.message_word  = '0;
        msg_ch.message_start = 1'b0;
        msg_ch.message_end   = 1'b0;
        dig_ch.ready         = 1'b0;
        for (int j = 0; j < 8; j++)
            hash_state[j] = Sha224Iv[j];
        for (int j = 0; j < 16; j++)
            block_buf[j] = '0;
        word_pos = '0;

        // Directed: a stray partial block with an end flag that must be ignored
        queue_word('1, 1'b0, 1'b0);
        queue_word('0, 1'b0, 1'b1);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        // Start mid-block together with end: reload wins, end ignored; message is "abc"
        queue_word(32'h6162_6380, 1'b1, 1'b1);
        for (int i = 1; i < 15; i++)
            queue_word('0, 1'b0, 1'b0);
        queue_word(32'h0000_0018, 1'b0, 1'b1);
        // No start after a digest: the next block carries on from the current hash
        for (int i = 0; i < 16; i++)
            queue_word((i % 2 == 0) ? '1 : '0, 1'b0, (i == 15));

        // Random: mostly well-formed messages, some continuations and some noise
        while (words_pending.size() < TotalWords)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n_noise = $urandom_range(1, 6);
                    repeat (n_noise)
                        queue_word(pick_word(), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
                1:
                begin
                    for (int i = 0; i < 16; i++)
                        queue_word(pick_word(), 1'b0, (i == 15) && ($urandom_range(0, 1) == 1));
                end
                default:
                begin
                    n_blocks = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
                    for (int b = 0; b < n_blocks; b++)
                        for (int i = 0; i < 16; i++)
                            queue_word(pick_word(), (b == 0) && (i == 0),
                                       (i == 15) ? (b == n_blocks - 1)
                                                 : ($urandom_range(0, 7) == 0));
                end
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every queued word has been taken by the block
        while (words_pending.size() != 0 || msg_ch.valid)
            @(negedge clk);
        while (digest_due.size() != 0)
            @(negedge clk);
        repeat (TailCycles) @(negedge clk);

        $display("run covered %0d message words in %0d hashed blocks", words_taken, blocks_hashed);
        $display("checked %0d digest items (%0d digests)", digest_items_seen,
                 digest_items_seen / 7);
        if (error_count == 0 && digest_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
